>>> design/linear_probe_method_cache_defines.svh
// assertion macros shared by the cache block
`ifndef LINEAR_PROBE_METHOD_CACHE_DEFINES_SVH
`define LINEAR_PROBE_METHOD_CACHE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lpmc_pkg.sv
package lpmc_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int NUM_TABLES  = 16;
    localparam int HOME_SHIFT  = 4;

    localparam int KEY_W      = 64;
    localparam int SLOT_SEL_W = 4;
    localparam int SLOT_SEL_N = 1 << SLOT_SEL_W;
    localparam int BANK_DEPTH = NUM_TABLES * TABLE_SLOTS;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int BKT_W      = $clog2(TABLE_SLOTS);

    typedef logic [2:0] t_status;
    localparam t_status ST_FOUND  = 3'd0;
    localparam t_status ST_MISS   = 3'd1;
    localparam t_status ST_STORED = 3'd2;
    localparam t_status ST_FULL   = 3'd3;
    localparam t_status ST_ZERO   = 3'd4;

    typedef logic [SLOT_SEL_N-1:0][TBL_W-1:0] t_tbl_map;

    function automatic t_tbl_map tbl_map_build();
        t_tbl_map m;
        for (int i = 0; i < SLOT_SEL_N; i++) begin
            m[i] = TBL_W'(i % NUM_TABLES);
        end
        return m;
    endfunction

    // table select folded into range
    localparam t_tbl_map TBL_MAP = tbl_map_build();

    typedef struct packed {
        logic              key_we;
        logic              val_we;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  wkey;
        logic [KEY_W-1:0]  wval;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [KEY_W-1:0] value;
    } t_result;

endpackage

>>> design/lpmc_ram.sv
module lpmc_ram #(
    parameter int W  = 64,
    parameter int D  = 256,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lpmc_seq.sv
module lpmc_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_kind,
    input  logic [3:0]              i_table_slot,
    input  logic [63:0]             i_key,
    input  logic [63:0]             i_fill_value,
    output lpmc_pkg::t_mem_req      o_mem_req,
    input  logic [63:0]             i_rd_key,
    input  logic [63:0]             i_rd_val,
    output lpmc_pkg::t_result       o_res,
    input  logic                    i_res_ready
);
    import lpmc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_kind, n_kind;
    logic [TBL_W-1:0]  r_tbl, n_tbl;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KEY_W-1:0]  r_val, n_val;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [BKT_W-1:0]  r_cnt, n_cnt;
    t_status           r_status, n_status;
    logic [KEY_W-1:0]  r_found, n_found;

    logic [ADDR_W-1:0] probe_addr;
    logic              key_hit;
    logic              key_empty;

    assign probe_addr = ADDR_W'(int'(r_tbl) * TABLE_SLOTS + int'(r_bkt));
    assign key_hit    = (i_rd_key == r_key);
    assign key_empty  = (i_rd_key == '0);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_kind   = r_kind;
        n_tbl    = r_tbl;
        n_key    = r_key;
        n_val    = r_val;
        n_bkt    = r_bkt;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_found  = r_found;

        o_mem_req.key_we = 1'b0;
        o_mem_req.val_we = 1'b0;
        o_mem_req.addr   = probe_addr;
        o_mem_req.wkey   = r_key;
        o_mem_req.wval   = r_val;

        case (r_state)
            S_CLEAR: begin
                // sweep every bucket to the empty marker
                o_mem_req.key_we = 1'b1;
                o_mem_req.addr   = r_clr;
                o_mem_req.wkey   = '0;
                n_clr            = r_clr + 1'b1;
                if (r_clr == ADDR_W'(BANK_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_tbl   = TBL_MAP[i_table_slot];
                    n_key   = i_key;
                    n_val   = i_fill_value;
                    n_bkt   = BKT_W'((i_key >> HOME_SHIFT) & KEY_W'(TABLE_SLOTS - 1));
                    n_cnt   = '0;
                    n_found = '0;
                    if (i_key == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_kind && key_hit) begin
                    n_status = ST_FOUND;
                    n_found  = i_rd_val;
                    n_state  = S_DONE;
                end else if (!r_kind && key_empty) begin
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else if (r_kind && (key_hit || key_empty)) begin
                    o_mem_req.key_we = 1'b1;
                    o_mem_req.val_we = 1'b1;
                    n_status         = ST_STORED;
                    n_state          = S_DONE;
                end else if (r_cnt == BKT_W'(TABLE_SLOTS - 1)) begin
                    n_status = r_kind ? ST_FULL : ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    n_bkt   = (r_bkt == BKT_W'(TABLE_SLOTS - 1)) ? '0 : r_bkt + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_ADDR;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_tbl    <= n_tbl;
        r_key    <= n_key;
        r_val    <= n_val;
        r_bkt    <= n_bkt;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.value  = r_found;

endmodule

>>> design/linear_probe_method_cache.sv
// Bank of linear-probe key/value caches, one table per slot.
// Input channel (i_in_valid / o_in_ready) carries a word of kind, table_slot,
// key and fill_value; kind 0 looks a key up, kind 1 stores the value.
// Output channel (o_out_valid / i_out_ready) returns one word per input word:
// status and found_value, in order.
// Each probe goes through the single-port key memory (address, then
// registered read and key compare); an item visits 1 to 16 buckets, and a
// zero key answers without any probe. o_in_ready rises again once the result
// has moved into the output register, which frees the next word while the
// result still waits for the receiver; a new word is taken only after the
// previous result has left the sequencer.
// After reset a clearing pass writes every one of the 256 buckets to empty,
// one per cycle; o_in_ready stays low until the pass ends.
// If the receiver stalls, the output register holds its word and a second
// finished result waits in the sequencer, which accepts nothing meanwhile.
`include "linear_probe_method_cache_defines.svh"

module linear_probe_method_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [3:0]  i_table_slot,
    input  logic [63:0] i_key,
    input  logic [63:0] i_fill_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_found_value
);
    import lpmc_pkg::*;

    t_mem_req         mem_req;
    t_result          res;
    logic             res_ready;
    logic [KEY_W-1:0] rd_key;
    logic [KEY_W-1:0] rd_val;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [KEY_W-1:0] r_out_value;

    lpmc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_table_slot (i_table_slot),
        .i_key        (i_key),
        .i_fill_value (i_fill_value),
        .o_mem_req    (mem_req),
        .i_rd_key     (rd_key),
        .i_rd_val     (rd_val),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    lpmc_ram #(.W(KEY_W), .D(BANK_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.key_we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wkey),
        .o_rdata (rd_key)
    );

    lpmc_ram #(.W(KEY_W), .D(BANK_DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.val_we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wval),
        .o_rdata (rd_val)
    );

    // output register frees the sequencer while the receiver stalls
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_status <= res.status;
            r_out_value  <= res.value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_value;

    `LPMC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `LPMC_ASSERT_NOW(a_no_accept_with_result, res.valid, !o_in_ready, "ready while result pending")
    `LPMC_ASSERT_NEXT(a_result_held, res.valid && !res_ready, res.valid, "pending result dropped")
    `LPMC_ASSERT_NOW(a_value_zero_unless_found, o_out_valid && (o_status != ST_FOUND), o_found_value == '0, "value without hit")

endmodule

>>> bench/linear_probe_method_cache_tb.sv
`timescale 1ns / 1ps

module linear_probe_method_cache_tb;
    import lpmc_pkg::*;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    localparam int N_SEED         = 21;
    localparam int RAND_ITEMS     = 1650;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [63:0] ALL1 = '1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [63:0] key;
        logic [63:0] val;
        logic        pinned;
        t_status     st;
        logic [63:0] rv;
    } t_word_row;

    typedef struct packed {
        t_status     st;
        logic [63:0] rv;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [3:0]  i_table_slot = 4'd0;
    logic [63:0] i_key = 64'h0;
    logic [63:0] i_fill_value = 64'h0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [63:0] o_found_value;

    // expectation typed into the directed table, travels with the word
    logic        drv_pinned = 1'b0;
    t_status     drv_status = ST_FOUND;
    logic [63:0] drv_value = 64'h0;

    logic [63:0] bank_keys [BANK_DEPTH] = '{default: '0};
    logic [63:0] bank_vals [BANK_DEPTH] = '{default: '0};
    logic [63:0] known_keys [NUM_TABLES][$];

    t_answer pending_answers[$];
    int      errors = 0;
    int      words_sent = 0;
    int      burst_left = 0;
    int      drains = 0;
    int      idle_cycles = 0;
    int      status_seen [8] = '{default: 0};

    int rx_mode = 0;
    int rx_span = 0;
    int rx_tick = 0;

    t_word_row seed_rows [N_SEED] = '{
        '{KIND_LOOKUP, 4'd0,  64'h10, 64'h0, 1'b1, ST_MISS, 64'h0},
        '{KIND_LOOKUP, 4'd0,  64'h0, ALL1, 1'b1, ST_ZERO, 64'h0},
        '{KIND_FILL,   4'd3,  64'h0, ALL1, 1'b1, ST_ZERO, 64'h0},
        '{KIND_LOOKUP, 4'd15, ALL1, 64'h0, 1'b1, ST_MISS, 64'h0},
        '{KIND_FILL,   4'd15, ALL1, ALL1, 1'b1, ST_STORED, 64'h0},
        '{KIND_LOOKUP, 4'd15, ALL1, 64'h0, 1'b1, ST_FOUND, ALL1},
        '{KIND_FILL,   4'd15, 64'hF1, 64'h1, 1'b1, ST_STORED, 64'h0},
        '{KIND_LOOKUP, 4'd15, 64'hF1, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_FILL,   4'd15, ALL1, 64'h0, 1'b1, ST_STORED, 64'h0},
        '{KIND_LOOKUP, 4'd15, ALL1, ALL1, 1'b0, ST_FOUND, 64'h0},
        '{KIND_LOOKUP, 4'd0,  ALL1, 64'h0, 1'b1, ST_MISS, 64'h0},
        '{KIND_FILL,   4'd0,  64'h1, 64'h8000_0000_0000_0000, 1'b1, ST_STORED, 64'h0},
        '{KIND_FILL,   4'd0,  64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
          1'b1, ST_STORED, 64'h0},
        '{KIND_LOOKUP, 4'd0,  64'h8000_0000_0000_0001, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_LOOKUP, 4'd0,  64'h1, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_LOOKUP, 4'd0,  64'h2, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_FILL,   4'd10, 64'hA5A5_5A5A_C3C3_3C3C, 64'h5A5A_A5A5_3C3C_C3C3,
          1'b1, ST_STORED, 64'h0},
        '{KIND_LOOKUP, 4'd10, 64'hA5A5_5A5A_C3C3_3C3C, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_FILL,   4'd15, 64'h0, 64'h0, 1'b1, ST_ZERO, 64'h0},
        '{KIND_LOOKUP, 4'd15, 64'hFF, 64'h0, 1'b0, ST_FOUND, 64'h0},
        '{KIND_LOOKUP, 4'd10, 64'hA5A5_5A5A_C3C3_3C3D, 64'h0, 1'b0, ST_FOUND, 64'h0}
    };

    linear_probe_method_cache i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_table_slot  (i_table_slot),
        .i_key         (i_key),
        .i_fill_value  (i_fill_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void cache_predict(input logic kind, input logic [3:0] slot,
                                          input logic [63:0] key, input logic [63:0] val,
                                          output t_status st, output logic [63:0] rv);
        int base;
        int home;
        int b;
        int i;
        base = (int'(slot) % NUM_TABLES) * TABLE_SLOTS;
        home = int'((key >> HOME_SHIFT) & 64'(TABLE_SLOTS - 1));
        rv = 64'h0;
        if (key == 64'h0) begin
            st = ST_ZERO;
        end else if (kind == KIND_LOOKUP) begin
            st = ST_MISS;
            for (i = 0; i < TABLE_SLOTS; i++) begin
                b = base + (home + i) % TABLE_SLOTS;
                if (bank_keys[b] == key) begin
                    st = ST_FOUND;
                    rv = bank_vals[b];
                    break;
                end
                if (bank_keys[b] == 64'h0) begin
                    break;
                end
            end
        end else begin
            st = ST_FULL;
            for (i = 0; i < TABLE_SLOTS; i++) begin
                b = base + (home + i) % TABLE_SLOTS;
                if (bank_keys[b] == 64'h0 || bank_keys[b] == key) begin
                    bank_keys[b] = key;
                    bank_vals[b] = val;
                    st = ST_STORED;
                    break;
                end
            end
        end
    endfunction

    function automatic t_word_row mk_word(input logic kind, input int tbl,
                                          input logic [63:0] key, input logic [63:0] val);
        t_word_row w;
        w.kind = kind;
        w.slot = 4'(tbl);
        w.key = key;
        w.val = val;
        w.pinned = 1'b0;
        w.st = ST_FOUND;
        w.rv = 64'h0;
        return w;
    endfunction

    // half the new keys cluster around the wrap point to force long probes
    function automatic logic [63:0] fresh_key();
        logic [63:0] key;
        logic [3:0]  home;
        if ($urandom_range(0, 1) == 0) begin
            home = 4'hE + 4'($urandom_range(0, 3));
        end else begin
            home = 4'($urandom_range(0, 15));
        end
        key = {$urandom, $urandom};
        key[7:4] = home;
        return key;
    endfunction

    function automatic logic [63:0] choose_key(input int tbl, input int pct_known);
        int n;
        n = known_keys[tbl].size();
        if (n != 0 && $urandom_range(0, 99) < pct_known) begin
            return known_keys[tbl][$urandom_range(0, n - 1)];
        end
        return fresh_key();
    endfunction

    // most fills go to the upper tables so the lower ones stay sparse
    function automatic int busy_table();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(0, 7);
        end
        return $urandom_range(8, 15);
    endfunction

    task automatic send_word(input t_word_row w);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 8)) begin
                @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_kind       <= w.kind;
        i_table_slot <= w.slot;
        i_key        <= w.key;
        i_fill_value <= w.val;
        drv_pinned   <= w.pinned;
        drv_status   <= w.st;
        drv_value    <= w.rv;
        if (w.kind == KIND_FILL && w.key != 64'h0) begin
            known_keys[int'(w.slot) % NUM_TABLES].push_back(w.key);
        end
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
        drains++;
        burst_left = 0;
    endtask

    initial begin : stimulus
        int seq;
        int len;
        int tbl;
        int j;
        logic [63:0] key;
        logic [63:0] val;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (seed_rows[r]) begin
            send_word(seed_rows[r]);
        end
        hold_until_drained();

        while (words_sent < N_SEED + RAND_ITEMS) begin
            seq = $urandom_range(0, 9);
            len = $urandom_range(4, 24);
            case (seq)
                5: begin
                    // flood one table past full, then sweep it with misses
                    tbl = $urandom_range(8, 15);
                    repeat ($urandom_range(17, 20)) begin
                        send_word(mk_word(KIND_FILL, tbl, fresh_key(), {$urandom, $urandom}));
                    end
                    repeat (4) begin
                        send_word(mk_word(KIND_LOOKUP, tbl, fresh_key(), {$urandom, $urandom}));
                    end
                end
                6: begin
                    tbl = $urandom_range(0, 15);
                    repeat (len) begin
                        send_word(mk_word(KIND_LOOKUP, tbl, choose_key(tbl, 90),
                                          {$urandom, $urandom}));
                    end
                end
                7: begin
                    tbl = busy_table();
                    for (j = 0; j < len / 2; j++) begin
                        key = choose_key(tbl, 80);
                        val = {$urandom, $urandom};
                        send_word(mk_word(KIND_FILL, tbl, key, val));
                        send_word(mk_word(KIND_LOOKUP, tbl, key, ~val));
                    end
                end
                8: begin
                    repeat (len) begin
                        key = ($urandom_range(0, 6) == 0) ? 64'h0 : {$urandom, $urandom};
                        send_word(mk_word(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                          key, {$urandom, $urandom}));
                    end
                end
                9: begin
                    hold_until_drained();
                end
                default: begin
                    repeat (len) begin
                        if ($urandom_range(0, 9) < 4) begin
                            tbl = busy_table();
                            send_word(mk_word(KIND_FILL, tbl, choose_key(tbl, 50),
                                              {$urandom, $urandom}));
                        end else begin
                            tbl = $urandom_range(0, 15);
                            send_word(mk_word(KIND_LOOKUP, tbl, choose_key(tbl, 65),
                                              {$urandom, $urandom}));
                        end
                    end
                end
            endcase
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            errors += pending_answers.size();
            $error("%0d expected results never arrived", pending_answers.size());
        end

        $display("run: %0d words (%0d directed), bursty sender, %0d drain pauses",
                 words_sent, N_SEED, drains);
        $display("results: found %0d, miss %0d, stored %0d, full %0d, zero key %0d",
                 status_seen[ST_FOUND], status_seen[ST_MISS], status_seen[ST_STORED],
                 status_seen[ST_FULL], status_seen[ST_ZERO]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // receiver stall pattern, switching between random modes
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_span <= $urandom_range(50, 400);
        end else begin
            rx_span <= rx_span - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 9) < 7);
            2: i_out_ready <= (rx_tick % 3 == 0);
            default: i_out_ready <= (rx_tick % 48 >= 36);
        endcase
    end

    always @(posedge i_clk) begin : scoreboard
        t_answer     ans;
        t_status     p_st;
        logic [63:0] p_rv;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    errors++;
                    $error("word with nothing pending: status %0d, found_value 0x%h",
                           o_status, o_found_value);
                end else begin
                    ans = pending_answers.pop_front();
                    status_seen[ans.st]++;
                    if (o_status !== ans.st) begin
                        errors++;
                        $error("status: expected %0d, got %0d", ans.st, o_status);
                    end
                    if (o_found_value !== ans.rv) begin
                        errors++;
                        $error("found_value: expected 0x%h, got 0x%h", ans.rv, o_found_value);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                cache_predict(i_kind, i_table_slot, i_key, i_fill_value, p_st, p_rv);
                if (drv_pinned) begin
                    ans.st = drv_status;
                    ans.rv = drv_value;
                end else begin
                    ans.st = p_st;
                    ans.rv = p_rv;
                end
                pending_answers.push_back(ans);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

>>> filelist.f
+incdir+design
design/lpmc_pkg.sv
design/lpmc_ram.sv
design/lpmc_seq.sv
design/linear_probe_method_cache.sv
bench/linear_probe_method_cache_tb.sv
